/* design/bpfm_pkg.sv */
// Shared types and codes for the buffer pool frame manager.
`timescale 1ns / 1ps
package bpfm_pkg;

  typedef enum logic [2:0] {
    ACT_PIN   = 3'd0,
    ACT_UNPIN = 3'd1,
    ACT_DIRTY = 3'd2,
    ACT_FORCE = 3'd3,
    ACT_FLUSH = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOTRES  = 2'd2;
  localparam logic [1:0] ST_PINNED  = 2'd3;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  localparam int OUT_DATA_W = 152;

  // one result item
  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         frame_index;
    logic               load_needed;
    logic               writeback_valid;
    logic [30:0]        writeback_page;
    logic signed [31:0] frame_page;
    logic               frame_dirty;
    logic [15:0]        frame_fix_count;
    logic [31:0]        read_io_count;
    logic [31:0]        write_io_count;
    logic               last;
  } res_t;

endpackage

/* design/bpfm_out_reg.sv */
// Output holding register for result items.
`timescale 1ns / 1ps
module bpfm_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  bpfm_pkg::res_t                      din,
  output logic                                space,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, frame_index, load_needed, writeback_valid, writeback_page,
  // frame_page, frame_dirty, frame_fix_count, read_io_count, write_io_count
  output logic [bpfm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  logic           valid_r;
  bpfm_pkg::res_t data_r;

  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tlast  = data_r.last;
  assign out_tdata  = {data_r.write_io_count, data_r.read_io_count, data_r.frame_fix_count,
                       data_r.frame_dirty, data_r.frame_page, data_r.writeback_page,
                       data_r.writeback_valid, data_r.load_needed, data_r.frame_index,
                       data_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

/* design/buffer_pool_frame_manager_unit.sv */
// Top level of the buffer pool frame manager: tag lookup and FIFO/LRU replacement.
`timescale 1ns / 1ps
// in_tready drops from the acceptance of an item until its result is loaded into the output
// register; the result is offered as in_tready rises again.
// Lookup walks the filled frames one per cycle; LRU reorder and the victim scan walk the
// order list one entry per cycle. Flush pool walks the order list once, plus output stalls.
// One item at a time; in_tready is high only in idle.
// Reset (rst_n low, synchronous): frames empty, counters zero, FIFO mode, pool size 16.
module buffer_pool_frame_manager_unit #(
  parameter int NUM_FRAMES = 16,
  parameter int PIN_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // page_number, frame_slot, zero fill
  input  logic [2:0]                      in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bpfm_pkg::OUT_DATA_W-1:0] out_tdata,  // status, frame_index, load_needed,
                                                      // writeback_valid, writeback_page,
                                                      // frame_page, frame_dirty,
                                                      // frame_fix_count, read_io_count,
                                                      // write_io_count
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [4:0]                      cfg_data
);

  // only the first 16 frames can ever fill
  localparam int NF  = (NUM_FRAMES < 16) ? NUM_FRAMES : 16;
  localparam int AW  = $clog2(NF);
  localparam int PW16 = (PIN_BITS > 16) ? PIN_BITS : 16;
  localparam logic [4:0] NF5 = 5'(NF);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOK  = 8'b0000_0010,
    S_OFIND = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_VICT  = 8'b0001_0000,
    S_FLUSH = 8'b0010_0000,
    S_RDF   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  // frame table
  logic [30:0]         page_r  [NF];
  logic                dirty_r [NF];
  logic [PIN_BITS-1:0] pins_r  [NF];
  logic [3:0]          order_r [NF];

  state_t         state_r, state_nxt;
  logic [4:0]     idx_r, idx_nxt;
  logic [4:0]     fc_r, fc_nxt;
  logic [3:0]     hit_r, hit_nxt;
  logic [PIN_BITS-1:0] pcur_r, pcur_nxt;
  logic [2:0]     act_r, act_nxt;
  logic [30:0]    pg_r, pg_nxt;
  logic           pend_r, pend_nxt;
  logic [30:0]    pend_page_r, pend_page_nxt;
  logic           mode_r;
  logic [4:0]     psize_r;
  logic [31:0]    rd_cnt_r, rd_cnt_nxt;
  logic [31:0]    wr_cnt_r, wr_cnt_nxt;
  bpfm_pkg::res_t res_r, res_nxt;

  // write strobes into the table
  logic                page_we, dirty_we, pins_we, order_we;
  logic [AW-1:0]       page_wa, dirty_wa, pins_wa, order_wa;
  logic [30:0]         page_wd;
  logic                dirty_wd;
  logic [PIN_BITS-1:0] pins_wd;
  logic [3:0]          order_wd;

  // single read port per array
  logic [3:0]          order_rd;
  logic [AW-1:0]       raddr;
  logic [30:0]         page_rd;
  logic                dirty_rd;
  logic [PIN_BITS-1:0] pins_rd;
  logic [PW16-1:0]     pins_wide;
  logic [4:0]          size_use;
  logic [4:0]          idx_dec;
  logic [4:0]          fc_dec;
  logic                in_acc;
  logic                emit;
  bpfm_pkg::res_t      emit_data;
  logic                out_space;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  assign order_rd = order_r[idx_r[AW-1:0]];
  // victim and flush scans look at the frame named by the order entry
  assign raddr    = (state_r == S_VICT || state_r == S_FLUSH) ? order_rd[AW-1:0]
                                                              : idx_r[AW-1:0];
  assign page_rd  = page_r[raddr];
  assign dirty_rd = dirty_r[raddr];
  assign pins_rd  = pins_r[raddr];
  assign pins_wide = PW16'(pins_rd);

  assign size_use = (psize_r == 5'd0) ? 5'd1 : ((psize_r > NF5) ? NF5 : psize_r);
  assign idx_dec  = idx_r - 5'd1;
  assign fc_dec   = fc_r - 5'd1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fc_nxt        = fc_r;
    hit_nxt       = hit_r;
    pcur_nxt      = pcur_r;
    act_nxt       = act_r;
    pg_nxt        = pg_r;
    pend_nxt      = pend_r;
    pend_page_nxt = pend_page_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    res_nxt       = res_r;
    page_we  = 1'b0; page_wa  = idx_r[AW-1:0]; page_wd  = pg_r;
    dirty_we = 1'b0; dirty_wa = idx_r[AW-1:0]; dirty_wd = 1'b0;
    pins_we  = 1'b0; pins_wa  = idx_r[AW-1:0]; pins_wd  = '0;
    order_we = 1'b0; order_wa = idx_r[AW-1:0]; order_wd = hit_r;
    emit      = 1'b0;
    emit_data = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_tuser;
          pg_nxt   = in_tdata[30:0];
          idx_nxt  = 5'd0;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          pend_nxt = 1'b0;
          case (in_tuser)
            bpfm_pkg::ACT_PIN, bpfm_pkg::ACT_UNPIN,
            bpfm_pkg::ACT_DIRTY, bpfm_pkg::ACT_FORCE: state_nxt = S_LOOK;
            bpfm_pkg::ACT_FLUSH: state_nxt = S_FLUSH;
            bpfm_pkg::ACT_READ: begin
              idx_nxt   = {1'b0, in_tdata[34:31]};
              state_nxt = S_RDF;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end

      S_LOOK: begin
        if (idx_r == fc_r) begin
          // page not resident
          if (act_r == bpfm_pkg::ACT_PIN) begin
            if (fc_r < size_use) begin
              page_we = 1'b1; page_wa = fc_r[AW-1:0];
              dirty_we = 1'b1; dirty_wa = fc_r[AW-1:0];
              pins_we = 1'b1; pins_wa = fc_r[AW-1:0]; pins_wd = PIN_BITS'(1);
              order_we = 1'b1; order_wa = fc_r[AW-1:0]; order_wd = fc_r[3:0];
              fc_nxt = fc_r + 5'd1;
              rd_cnt_nxt = rd_cnt_r + 32'd1;
              res_nxt.load_needed = 1'b1;
              res_nxt.frame_index = fc_r[3:0];
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = 5'd0;
              state_nxt = S_VICT;
            end
          end else begin
            res_nxt.status = bpfm_pkg::ST_NOTRES;
            state_nxt = S_EMIT;
          end
        end else if (page_rd == pg_r) begin
          hit_nxt  = idx_r[3:0];
          pcur_nxt = pins_rd;
          state_nxt = S_EMIT;
          case (act_r)
            bpfm_pkg::ACT_PIN: begin
              res_nxt.frame_index = idx_r[3:0];
              if (mode_r) begin
                idx_nxt   = 5'd0;
                state_nxt = S_OFIND;
              end else begin
                pins_we = 1'b1;
                pins_wd = (pins_rd == '1) ? pins_rd : pins_rd + PIN_BITS'(1);
              end
            end
            bpfm_pkg::ACT_UNPIN: begin
              pins_we = 1'b1;
              pins_wd = (pins_rd == '0) ? pins_rd : pins_rd - PIN_BITS'(1);
            end
            bpfm_pkg::ACT_DIRTY: begin
              dirty_we = 1'b1; dirty_wd = 1'b1;
            end
            bpfm_pkg::ACT_FORCE: begin
              if (dirty_rd) begin
                if (pins_rd != '0) begin
                  res_nxt.status = bpfm_pkg::ST_PINNED;
                end else begin
                  res_nxt.writeback_valid = 1'b1;
                  res_nxt.writeback_page  = page_rd;
                  dirty_we   = 1'b1;
                  wr_cnt_nxt = wr_cnt_r + 32'd1;
                end
              end
            end
            default: ;
          endcase
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      // find the hit frame's place in the order list
      S_OFIND: begin
        if (order_rd == hit_r || idx_r == fc_r) begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      // close the gap, one entry a cycle, then append at the newest end
      S_SHIFT: begin
        order_we = 1'b1;
        if (idx_r < fc_r) begin
          order_wa = idx_dec[AW-1:0];
          order_wd = order_rd;
          idx_nxt  = idx_r + 5'd1;
        end else begin
          order_wa = fc_dec[AW-1:0];
          order_wd = hit_r;
          if (!res_r.load_needed) begin
            pins_we = 1'b1;
            pins_wa = hit_r[AW-1:0];
            pins_wd = (pcur_r == '1) ? pcur_r : pcur_r + PIN_BITS'(1);
          end
          state_nxt = S_EMIT;
        end
      end

      S_VICT: begin
        if (idx_r == fc_r) begin
          res_nxt.status = bpfm_pkg::ST_NOSPACE;
          state_nxt = S_EMIT;
        end else if (pins_rd == '0) begin
          hit_nxt = order_rd;
          if (dirty_rd) begin
            res_nxt.writeback_valid = 1'b1;
            res_nxt.writeback_page  = page_rd;
            wr_cnt_nxt = wr_cnt_r + 32'd1;
          end
          page_we = 1'b1; page_wa = order_rd[AW-1:0];
          dirty_we = 1'b1; dirty_wa = order_rd[AW-1:0];
          pins_we = 1'b1; pins_wa = order_rd[AW-1:0]; pins_wd = PIN_BITS'(1);
          rd_cnt_nxt = rd_cnt_r + 32'd1;
          res_nxt.load_needed = 1'b1;
          res_nxt.frame_index = order_rd;
          idx_nxt   = idx_r + 5'd1;
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      // a found write-back is held until the next one shows whether it is the last
      S_FLUSH: begin
        if (idx_r == fc_r) begin
          res_nxt.writeback_valid = pend_r;
          res_nxt.writeback_page  = pend_r ? pend_page_r : 31'd0;
          state_nxt = S_EMIT;
        end else if (dirty_rd && pins_rd == '0) begin
          if (!pend_r || out_space) begin
            if (pend_r) begin
              emit = 1'b1;
              emit_data.writeback_valid = 1'b1;
              emit_data.writeback_page  = pend_page_r;
              emit_data.read_io_count   = rd_cnt_r;
              emit_data.write_io_count  = wr_cnt_r;
            end
            pend_nxt      = 1'b1;
            pend_page_nxt = page_rd;
            dirty_we = 1'b1; dirty_wa = order_rd[AW-1:0];
            wr_cnt_nxt = wr_cnt_r + 32'd1;
            idx_nxt    = idx_r + 5'd1;
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_RDF: begin
        if (idx_r < fc_r) begin
          res_nxt.frame_page      = {1'b0, page_rd};
          res_nxt.frame_dirty     = dirty_rd;
          res_nxt.frame_fix_count = pins_wide[15:0];
        end else begin
          res_nxt.frame_page = -32'sd1;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_space) begin
          emit = 1'b1;
          emit_data = res_r;
          emit_data.read_io_count  = rd_cnt_r;
          emit_data.write_io_count = wr_cnt_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fc_r     <= 5'd0;
      mode_r   <= 1'b0;
      psize_r  <= 5'd16;
      rd_cnt_r <= 32'd0;
      wr_cnt_r <= 32'd0;
      pend_r   <= 1'b0;
      idx_r    <= 5'd0;
    end else begin
      state_r  <= state_nxt;
      fc_r     <= fc_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      wr_cnt_r <= wr_cnt_nxt;
      pend_r   <= pend_nxt;
      idx_r    <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpfm_pkg::CFG_MODE: mode_r  <= cfg_data[0];
          bpfm_pkg::CFG_SIZE: psize_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r       <= hit_nxt;
    pcur_r      <= pcur_nxt;
    act_r       <= act_nxt;
    pg_r        <= pg_nxt;
    pend_page_r <= pend_page_nxt;
    res_r       <= res_nxt;
  end

  // pages and order entries are only read below the fill count, so they need no reset
  always_ff @(posedge clk) begin
    if (page_we) page_r[page_wa] <= page_wd;
    if (order_we) order_r[order_wa] <= order_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        dirty_r[i] <= 1'b0;
        pins_r[i]  <= '0;
      end
    end else begin
      if (dirty_we) dirty_r[dirty_wa] <= dirty_wd;
      if (pins_we) pins_r[pins_wa] <= pins_wd;
    end
  end

  bpfm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .din        (emit_data),
    .space      (out_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
